>>> hdl/sorted_list_insert_delete_macros.svh
`ifndef SORTED_LIST_INSERT_DELETE_MACROS_SVH
`define SORTED_LIST_INSERT_DELETE_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define SLI_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define SLI_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/sli_pkg.sv
`default_nettype none

package sli_pkg;

    typedef enum logic [1:0] {
        REQ_INSERT = 2'd0,
        REQ_DELETE = 2'd1,
        REQ_CLEAR  = 2'd2
    } req_t;

    typedef enum logic [1:0] {
        ST_DONE    = 2'd0,
        ST_NOMATCH = 2'd1,
        ST_FULL    = 2'd2
    } status_t;

    localparam logic signed [31:0] EMPTY_HEAD = -32'sd1;

    typedef struct packed {
        logic [1:0]         req_type;
        logic signed [31:0] item_value;
    } req_beat_t;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] head_value;
        logic               is_empty;
        logic [4:0]         entry_count;
    } rsp_beat_t;

    // broadcast to every cell
    typedef struct packed {
        logic               ins;
        logic               del;
        logic signed [31:0] value;
    } cell_cmd_t;

    // compare flags a cell shows its right neighbor
    typedef struct packed {
        logic gt;
        logic ge;
    } cell_flags_t;

endpackage

`default_nettype wire

>>> hdl/sli_cell.sv
`default_nettype none

module sli_cell (
    input  wire                       clk,
    input  sli_pkg::cell_cmd_t        cmd,
    input  wire                       occ,
    input  sli_pkg::cell_flags_t      left_flags,
    input  wire logic signed [31:0]   left_val,
    input  wire logic signed [31:0]   right_val,
    output sli_pkg::cell_flags_t      flags,
    output logic                      hit,
    output logic signed [31:0]        val,
    output logic signed [31:0]        val_next
);

    logic signed [31:0] val_reg;

    assign val      = val_reg;
    assign flags.gt = occ && (val_reg > cmd.value);
    assign flags.ge = occ && (val_reg >= cmd.value);
    // first entry not above the value, and equal to it
    assign hit      = occ && !flags.gt && left_flags.gt && (val_reg == cmd.value);

    always_comb
    begin
        val_next = val_reg;
        if (cmd.ins && !flags.ge)
        begin
            val_next = left_flags.ge ? cmd.value : left_val;
        end
        else if (cmd.del && !flags.gt)
        begin
            val_next = right_val;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
    end

endmodule

`default_nettype wire

>>> hdl/sorted_list_insert_delete.sv
`default_nettype none

// Sorted store of signed 32-bit values, largest at the head.
// Request channel req_*: one beat carries req_type (insert, delete, clear)
// and item_value. Response channel rsp_*: one beat per request with status,
// head value (-1 when empty), empty flag and entry count after the request.
// A beat moves at a rising edge with valid high and stall low.
// For each request a row of CAPACITY cells compares the value against all
// entries at once and each cell takes its own, its left or its right
// neighbor's value, so the response is registered in the cycle after the
// request beat. With rsp_stall low one request is taken in every cycle.
// While a response waits under rsp_stall, req_stall is high and no request
// is taken; the waiting response holds.
// Reset empties the store (count to zero) and drops rsp_valid; the entry
// values themselves are not cleared. An insert into a full store answers
// ST_FULL; a delete without a match answers ST_NOMATCH.
module sorted_list_insert_delete #(
    parameter int CAPACITY = 16
) (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 req_valid,
    output logic                req_stall,
    input  sli_pkg::req_beat_t  req_data,
    output logic                rsp_valid,
    input  wire                 rsp_stall,
    output sli_pkg::rsp_beat_t  rsp_data
);

    localparam int CW = $clog2(CAPACITY + 1);

    logic [CW-1:0]        count_reg;
    logic [CW-1:0]        count_next;
    logic                 rsp_valid_reg;
    logic                 rsp_valid_next;
    sli_pkg::rsp_beat_t   rsp_data_reg;
    sli_pkg::rsp_beat_t   rsp_data_next;

    logic                 accept;
    logic                 full;
    logic                 found;
    logic                 is_ins;
    logic                 is_del;
    sli_pkg::cell_cmd_t   cmd;

    sli_pkg::cell_flags_t flags    [CAPACITY];
    logic                 hit      [CAPACITY];
    logic [CAPACITY-1:0]  hit_vec;
    logic signed [31:0]   val      [CAPACITY];
    logic signed [31:0]   val_next [CAPACITY];

    assign req_stall = rsp_valid_reg && rsp_stall;
    assign accept    = req_valid && !req_stall;
    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_data_reg;

    assign is_ins = (req_data.req_type == sli_pkg::REQ_INSERT);
    assign is_del = (req_data.req_type == sli_pkg::REQ_DELETE);
    assign full   = (count_reg == CW'(CAPACITY));
    assign found  = |hit_vec;

    assign cmd.ins   = accept && is_ins && !full;
    assign cmd.del   = accept && is_del && found;
    assign cmd.value = req_data.item_value;

    genvar i;
    generate
        for (i = 0; i < CAPACITY; i++)
        begin : g_cell
            sli_pkg::cell_flags_t lf;
            logic signed [31:0]   lv;
            logic signed [31:0]   rv;

            if (i == 0)
            begin : g_head
                assign lf.gt = 1'b1;
                assign lf.ge = 1'b1;
                assign lv    = req_data.item_value;
            end
            else
            begin : g_body
                assign lf = flags[i-1];
                assign lv = val[i-1];
            end

            if (i == CAPACITY - 1)
            begin : g_tail
                assign rv = val[i];
            end
            else
            begin : g_inner
                assign rv = val[i+1];
            end

            assign hit_vec[i] = hit[i];

            sli_cell u_cell (
                .clk        (clk),
                .cmd        (cmd),
                .occ        (count_reg > CW'(i)),
                .left_flags (lf),
                .left_val   (lv),
                .right_val  (rv),
                .flags      (flags[i]),
                .hit        (hit[i]),
                .val        (val[i]),
                .val_next   (val_next[i])
            );
        end
    endgenerate

    always_comb
    begin
        count_next                = count_reg;
        rsp_data_next.status      = sli_pkg::ST_DONE;
        if (accept)
        begin
            case (req_data.req_type)
                sli_pkg::REQ_INSERT:
                begin
                    if (full)
                    begin
                        rsp_data_next.status = sli_pkg::ST_FULL;
                    end
                    else
                    begin
                        count_next = count_reg + CW'(1);
                    end
                end
                sli_pkg::REQ_DELETE:
                begin
                    if (found)
                    begin
                        count_next = count_reg - CW'(1);
                    end
                    else
                    begin
                        rsp_data_next.status = sli_pkg::ST_NOMATCH;
                    end
                end
                sli_pkg::REQ_CLEAR:
                begin
                    count_next = '0;
                end
                default:
                begin
                    count_next = count_reg;
                end
            endcase
        end
        rsp_data_next.is_empty    = (count_next == '0);
        rsp_data_next.head_value  = (count_next == '0) ? sli_pkg::EMPTY_HEAD : val_next[0];
        rsp_data_next.entry_count = 5'(count_next);
    end

    assign rsp_valid_next = accept || (rsp_valid_reg && rsp_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rsp_data_reg <= rsp_data_next;
        end
    end

endmodule

`default_nettype wire

>>> hdl/sli_checker.sv
`default_nettype none

`include "sorted_list_insert_delete_macros.svh"

module sli_checker #(
    parameter int CAPACITY = 16
) (
    input wire                clk,
    input wire                rst_n,
    input wire                req_valid,
    input wire                req_stall,
    input sli_pkg::req_beat_t req_data,
    input wire                rsp_valid,
    input wire                rsp_stall,
    input sli_pkg::rsp_beat_t rsp_data
);

    `SLI_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data), "stalled response beat changed")
    `SLI_ASSERT_NEXT(a_one_cycle, req_valid && !req_stall, rsp_valid, "no response one cycle after request beat")
    `SLI_ASSERT_NEXT(a_clear, req_valid && !req_stall && req_data.req_type == sli_pkg::REQ_CLEAR, rsp_data.entry_count == 5'd0 && rsp_data.is_empty && rsp_data.status == sli_pkg::ST_DONE, "clear left entries")
    `SLI_ASSERT_NOW(a_empty_head, rsp_valid && rsp_data.is_empty, rsp_data.head_value == sli_pkg::EMPTY_HEAD && rsp_data.status != sli_pkg::ST_FULL, "empty store with bad head or status")
    `SLI_ASSERT_NOW(a_empty_count, rsp_valid && CAPACITY < 32, rsp_data.is_empty == (rsp_data.entry_count == 5'd0), "empty flag disagrees with count")

endmodule

bind sorted_list_insert_delete sli_checker #(
    .CAPACITY (CAPACITY)
) u_sli_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req_data  (req_data),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp_data  (rsp_data)
);

`default_nettype wire
